// ----- design/csfd_pkg.sv -----
// ----------------------------------------------------------------------------
// csfd_pkg
// Shared types and codes for the compact record stream field decoder.
// ----------------------------------------------------------------------------
package csfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;

  typedef enum logic [2:0] {
    KIND_COUNT = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_UNS   = 3'd3,
    KIND_SGN   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ValueW-1:0]  value;
    logic               field_end;
    logic               record_end;
    logic               stream_end;
  } csfd_result_t;

endpackage

// ----- design/compact_struct_field_decoder.sv -----
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid entry while
// the output is stalled. Throughput: one byte per cycle while the input is not
// stalled; headers of non-empty fields and non-final integer bytes give no result.
// The input stalls only while the skid entry of the output is held.
// Reset (rst_ni, asynchronous, active low) returns the decoder to waiting for a
// count byte and empties the output register and the skid entry.
// ----------------------------------------------------------------------------
// compact_struct_field_decoder
// Decodes a compact record stream, one byte per request, into typed results.
// ----------------------------------------------------------------------------
module compact_struct_field_decoder
  import csfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [ValueW-1:0]  value_o,
  output logic               field_end_o,
  output logic               record_end_o,
  output logic               stream_end_o
);

  logic          accept;
  logic          res_valid;
  logic          full;
  csfd_result_t  res;
  csfd_result_t  out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  csfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  csfd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o       = out_data.kind;
  assign value_o      = out_data.value;
  assign field_end_o  = out_data.field_end;
  assign record_end_o = out_data.record_end;
  assign stream_end_o = out_data.stream_end;

endmodule

// ----- design/csfd_core.sv -----
// ----------------------------------------------------------------------------
// csfd_core
// Decoder state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module csfd_core
  import csfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [ByteW-1:0]  data_byte_i,
  output logic              res_valid_o,
  output csfd_result_t      res_o
);

  typedef enum logic [3:0] {
    PH_COUNT  = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_STRING = 4'b0100,
    PH_INT    = 4'b1000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         records_left_q, records_left_d;
  logic [5:0]         bytes_left_q, bytes_left_d;
  logic [4:0]         field_length_q, field_length_d;
  logic [ValueW-1:0]  accumulator_q, accumulator_d;
  logic               signed_field_q, signed_field_d;
  logic               last_field_q, last_field_d;

  logic               fin;
  kind_e              fin_kind;
  logic [ValueW-1:0]  fin_value;
  logic               last_sel;
  logic [7:0]         rec_dec;
  logic [5:0]         bytes_dec;
  kind_e              int_kind;

  // Sign extension applies only to signed integers of one to three bytes.
  function automatic logic [ValueW-1:0] int_result(input logic [ValueW-1:0] v,
                                                   input logic              sgn,
                                                   input logic [4:0]        len);
    logic [ValueW-1:0] r;
    r = v;
    if (sgn) begin
      if (len == 5'd1 && v[7]) begin
        r = v | 32'hFFFF_FF00;
      end else if (len == 5'd2 && v[15]) begin
        r = v | 32'hFFFF_0000;
      end else if (len == 5'd3 && v[23]) begin
        r = v | 32'hFF00_0000;
      end
    end
    return r;
  endfunction

  assign rec_dec   = records_left_q - 8'd1;
  assign bytes_dec = bytes_left_q - 6'd1;
  assign int_kind  = signed_field_q ? KIND_SGN : KIND_UNS;

  always_comb begin
    phase_d        = phase_q;
    records_left_d = records_left_q;
    bytes_left_d   = bytes_left_q;
    field_length_d = field_length_q;
    accumulator_d  = accumulator_q;
    signed_field_d = signed_field_q;
    last_field_d   = last_field_q;
    res_valid_o    = 1'b0;
    res_o          = '{kind: KIND_COUNT, value: '0, field_end: 1'b0,
                       record_end: 1'b0, stream_end: 1'b0};
    fin            = 1'b0;
    fin_kind       = KIND_CHAR;
    fin_value      = '0;
    last_sel       = last_field_q;

    unique case (phase_q)
      PH_COUNT: begin
        records_left_d = data_byte_i;
        res_valid_o    = 1'b1;
        res_o.value    = {{(ValueW-ByteW){1'b0}}, data_byte_i};
        if (data_byte_i == 8'd0) begin
          res_o.stream_end = 1'b1;
        end else begin
          phase_d = PH_HEADER;
        end
      end
      PH_HEADER: begin
        last_field_d = data_byte_i[7];
        last_sel     = data_byte_i[7];
        if (data_byte_i[6]) begin
          bytes_left_d = data_byte_i[5:0];
          if (data_byte_i[5:0] == 6'd0) begin
            fin      = 1'b1;
            fin_kind = KIND_EMPTY;
          end else begin
            phase_d = PH_STRING;
          end
        end else begin
          signed_field_d = data_byte_i[5];
          field_length_d = data_byte_i[4:0];
          bytes_left_d   = {1'b0, data_byte_i[4:0]};
          accumulator_d  = '0;
          if (data_byte_i[4:0] == 5'd0) begin
            fin      = 1'b1;
            fin_kind = data_byte_i[5] ? KIND_SGN : KIND_UNS;
          end else begin
            phase_d = PH_INT;
          end
        end
      end
      PH_STRING: begin
        bytes_left_d = bytes_dec;
        if (bytes_dec == 6'd0) begin
          fin       = 1'b1;
          fin_kind  = KIND_CHAR;
          fin_value = {{(ValueW-ByteW){1'b0}}, data_byte_i};
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_CHAR;
          res_o.value = {{(ValueW-ByteW){1'b0}}, data_byte_i};
        end
      end
      PH_INT: begin
        accumulator_d = {accumulator_q[ValueW-ByteW-1:0], data_byte_i};
        bytes_left_d  = bytes_dec;
        if (bytes_dec == 6'd0) begin
          fin       = 1'b1;
          fin_kind  = int_kind;
          fin_value = int_result(accumulator_d, signed_field_q, field_length_q);
        end
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase

    // Closing a field also advances the record count when it ends a record.
    if (fin) begin
      res_valid_o      = 1'b1;
      res_o.kind       = fin_kind;
      res_o.value      = fin_value;
      res_o.field_end  = 1'b1;
      res_o.record_end = last_sel;
      phase_d          = PH_HEADER;
      if (last_sel) begin
        records_left_d = rec_dec;
        if (rec_dec == 8'd0) begin
          res_o.stream_end = 1'b1;
          phase_d          = PH_COUNT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_COUNT;
      records_left_q <= '0;
      bytes_left_q   <= '0;
      field_length_q <= '0;
      accumulator_q  <= '0;
      signed_field_q <= 1'b0;
      last_field_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      records_left_q <= records_left_d;
      bytes_left_q   <= bytes_left_d;
      field_length_q <= field_length_d;
      accumulator_q  <= accumulator_d;
      signed_field_q <= signed_field_d;
      last_field_q   <= last_field_d;
    end
  end

  a_stream_end_to_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.stream_end |=> phase_q == PH_COUNT)
    else $error("stream end did not return to the count phase");

  a_record_end_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.record_end |-> res_o.field_end && res_o.kind != KIND_COUNT)
    else $error("record end without a field end");

  a_pending_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_INT || phase_q == PH_STRING) |-> bytes_left_q != 6'd0)
    else $error("field body phase with no bytes left");

endmodule

// ----- design/csfd_skid.sv -----
// ----------------------------------------------------------------------------
// csfd_skid
// Output register with a skid entry so the input side sees a registered stall.
// ----------------------------------------------------------------------------
module csfd_skid
  import csfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csfd_result_t  push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output csfd_result_t  out_data_o
);

  logic          main_valid_q;
  logic          skid_valid_q;
  csfd_result_t  main_q;
  csfd_result_t  skid_q;
  logic          main_free;

  assign main_free   = !main_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      // No push can arrive while the skid entry is held, since it stalls the input.
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end
    if (!main_free && push_i) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held with an empty output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("request pushed into a full output buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> main_valid_q && !skid_valid_q)
    else $error("skid entry did not move to the output register");

endmodule
